### hdl/essg_pkg.sv
package essg_pkg;

    // Widths of the datapath
    localparam int QUARTER_TABLE_BITS = 8;
    localparam int SAMPLE_BITS        = 16;
    localparam int PHASE_BITS         = 48;
    localparam int RATE_BITS          = 32;
    localparam int GROWTH_SHIFT       = 40;
    localparam int PADDR_BITS         = 4;
    localparam int PDATA_BITS         = 64;

    localparam int ROM_SIZE = 1 << QUARTER_TABLE_BITS;

    // Largest sample magnitude
    localparam logic [SAMPLE_BITS-1:0] AMP = SAMPLE_BITS'((1 << (SAMPLE_BITS - 1)) - 1);

    // Nyquist: half a turn
    localparam logic [PHASE_BITS-1:0] HALF_TURN = PHASE_BITS'(1) << (PHASE_BITS - 1);

    // Reset values of the registers
    localparam logic [PHASE_BITS-1:0] START_STEP_RESET = PHASE_BITS'(64'd63826525331);
    localparam logic [RATE_BITS-1:0]  SWEEP_RATE_RESET = RATE_BITS'(32'd8640940);

    // 2*pi in Q30
    localparam logic [63:0] TWO_PI_Q30 = 64'd6746518852;

    // Register select (paddr bit 3, registers on 8-byte spacing)
    localparam logic REG_START_STEP = 1'b0;
    localparam logic REG_SWEEP_RATE = 1'b1;

    typedef logic [SAMPLE_BITS-1:0] t_rom [ROM_SIZE];

    // Registered lookup result handed back to the top level
    typedef struct packed {
        logic                   neg;
        logic [SAMPLE_BITS-1:0] mag;
    } t_sine_rd;

    // Build the quarter-wave table: Taylor series to the x^15 term in Q30
    function automatic t_rom build_sine_rom();
        t_rom        rom;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] v;
        for (int i = 0; i < ROM_SIZE; i++) begin
            x    = (64'(i) * TWO_PI_Q30) >> (QUARTER_TABLE_BITS + 2);
            x2   = (x * x) >> 30;
            term = x;
            sum  = x;
            for (int k = 1; k <= 7; k++) begin
                term = ((term * x2) >> 30) / 64'((2 * k) * (2 * k + 1));
                if ((k & 1) != 0) begin
                    sum = sum - term;
                end else begin
                    sum = sum + term;
                end
            end
            v = (sum * 64'(AMP) + (64'd1 << 29)) >> 30;
            if (v > 64'(AMP)) begin
                v = 64'(AMP);
            end
            rom[i] = SAMPLE_BITS'(v);
        end
        return rom;
    endfunction

endpackage

### hdl/exponential_sine_sweep_generator_core.sv
// Exponential sine sweep generator. Each request with tick set returns one signed
// sample, the sine of the running phase, while the phase step is at most half a turn;
// after that every sample is zero and done_res is held high. The block takes one
// request per clock while o_stall is low. The table read is registered when a request
// is accepted, and the output register loads from it once that register is free or
// drained, and offers the result on o_valid. The step update loop, one 48 x 32 growth
// product (two 24 x 32 partial products) and its adds, is combinational, which is what
// allows one request per clock. A request with tick clear is taken and yields no
// result. Writing start_step (address 0) restarts the sweep; sweep_rate lies at address 8.
module exponential_sine_sweep_generator_core (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    // request channel
    input  logic                                   i_valid,
    output logic                                   o_stall,
    input  logic                                   i_tick,
    // result channel
    output logic                                   o_valid,
    input  logic                                   i_stall,
    output logic signed [essg_pkg::SAMPLE_BITS-1:0] o_sample,
    output logic                                   o_done_res,
    // configuration port
    input  logic                                   psel,
    input  logic                                   penable,
    input  logic                                   pwrite,
    input  logic [essg_pkg::PADDR_BITS-1:0]        paddr,
    input  logic [essg_pkg::PDATA_BITS-1:0]        pwdata,
    output logic [essg_pkg::PDATA_BITS-1:0]        prdata,
    output logic                                   pready
);

    localparam int PB  = essg_pkg::PHASE_BITS;
    localparam int RB  = essg_pkg::RATE_BITS;
    localparam int SB  = essg_pkg::SAMPLE_BITS;
    localparam int QTB = essg_pkg::QUARTER_TABLE_BITS;
    localparam int HB  = PB / 2;

    logic                  cfg_wr;
    logic                  wr_start;
    logic                  in_acc;
    logic                  item;
    logic                  s1_adv;
    logic                  below;

    logic [PB-1:0]         r_start_step;
    logic [RB-1:0]         r_sweep_rate;
    logic [PB-1:0]         r_phase;
    logic [PB-1:0]         r_step;
    logic                  r_done;
    logic [PB-1:0]         n_phase;
    logic [PB-1:0]         n_step;
    logic                  n_done;

    logic [HB+RB-1:0]      prod_hi;
    logic [HB+RB-1:0]      prod_lo;
    logic [HB+RB:0]        prod_mid;
    logic [PB-1:0]         growth;

    logic                  r_s1_valid;
    logic                  r_s1_zero;
    logic                  r_s1_done;
    essg_pkg::t_sine_rd    sine_rd;
    logic [SB-1:0]         s1_sample;

    logic                  r_out_valid;
    logic [SB-1:0]         r_sample;
    logic                  r_done_out;

    // Configuration port
    assign pready   = 1'b1;
    assign cfg_wr   = psel && penable && pwrite && pready;
    assign wr_start = cfg_wr && (paddr[3] == essg_pkg::REG_START_STEP);
    assign prdata   = (paddr[3] == essg_pkg::REG_SWEEP_RATE)
                    ? essg_pkg::PDATA_BITS'(r_sweep_rate)
                    : essg_pkg::PDATA_BITS'(r_start_step);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_step <= essg_pkg::START_STEP_RESET;
            r_sweep_rate <= essg_pkg::SWEEP_RATE_RESET;
        end else if (cfg_wr) begin
            if (paddr[3] == essg_pkg::REG_START_STEP) begin
                r_start_step <= pwdata[PB-1:0];
            end else begin
                r_sweep_rate <= pwdata[RB-1:0];
            end
        end
    end

    // Handshake: stage one moves on when the output register is free or drained
    assign s1_adv  = !r_out_valid || !i_stall;
    assign o_stall = r_s1_valid && !s1_adv;
    assign in_acc  = i_valid && !o_stall;
    assign item    = in_acc && i_tick;

    // Step growth: step * rate >> 40, split into two partial products
    assign prod_hi  = (HB+RB)'(r_step[PB-1:HB]) * (HB+RB)'(r_sweep_rate);
    assign prod_lo  = (HB+RB)'(r_step[HB-1:0]) * (HB+RB)'(r_sweep_rate);
    assign prod_mid = (HB+RB+1)'(prod_lo)
                    + (HB+RB+1)'({prod_hi[essg_pkg::GROWTH_SHIFT-HB-1:0], HB'(0)});
    assign growth   = PB'(prod_hi[HB+RB-1:essg_pkg::GROWTH_SHIFT-HB])
                    + PB'(prod_mid[HB+RB:essg_pkg::GROWTH_SHIFT]);

    assign below = (r_step <= essg_pkg::HALF_TURN);

    // Advance phase and step, or end the sweep
    always_comb begin
        n_phase = r_phase;
        n_step  = r_step;
        n_done  = r_done;
        if (wr_start) begin
            n_phase = '0;
            n_step  = pwdata[PB-1:0];
            n_done  = 1'b0;
        end else if (item) begin
            if (below) begin
                n_phase = r_phase + r_step;
                n_step  = r_step + growth;
            end else begin
                n_done  = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= '0;
            r_step  <= essg_pkg::START_STEP_RESET;
            r_done  <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_step  <= n_step;
            r_done  <= n_done;
        end
    end

    // Table read for the current phase
    essg_sine_lookup u_sine (
        .i_clk      (i_clk),
        .i_rd_en    (item),
        .i_quad_idx (r_phase[PB-1 -: QTB+2]),
        .o_rd       (sine_rd)
    );

    // Stage one: request in flight through the table read
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_acc) begin
            r_s1_valid <= i_tick;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (item) begin
            r_s1_zero <= !below;
            r_s1_done <= n_done;
        end
    end

    // Form the signed sample
    assign s1_sample = r_s1_zero ? '0
                     : (sine_rd.neg ? SB'(~sine_rd.mag + 1'b1) : sine_rd.mag);

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv && r_s1_valid) begin
            r_sample   <= s1_sample;
            r_done_out <= r_s1_done;
        end
    end

    assign o_valid    = r_out_valid;
    assign o_sample   = r_sample;
    assign o_done_res = r_done_out;

    // A finished sweep only ever yields silence
    a_done_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_done_res) |-> (o_sample == '0))
        else $error("nonzero sample after sweep end");

    // Done stays set until start_step is rewritten
    a_done_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_done && !wr_start) |=> r_done)
        else $error("done flag dropped without restart");

    // A start_step write restarts phase and step
    a_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_start |=> (r_phase == '0) && !r_done && (r_step == $past(pwdata[PB-1:0])))
        else $error("restart did not reload the sweep");

    // Stall only with a request held in stage one behind a full output
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_s1_valid && r_out_valid && i_stall))
        else $error("stall without a blocked request");

endmodule

### hdl/essg_sine_lookup.sv
module essg_sine_lookup (
    input  logic                                    i_clk,
    input  logic                                    i_rd_en,
    input  logic [essg_pkg::QUARTER_TABLE_BITS+1:0] i_quad_idx,
    output essg_pkg::t_sine_rd                      o_rd
);

    localparam int QTB = essg_pkg::QUARTER_TABLE_BITS;

    // Quarter-wave table, read through a register
    localparam essg_pkg::t_rom SINE_ROM = essg_pkg::build_sine_rom();

    logic [1:0]                         quad;
    logic [QTB-1:0]                     idx;
    logic [QTB-1:0]                     addr;
    logic                               pole;
    logic [essg_pkg::SAMPLE_BITS-1:0]   r_mag;
    logic                               r_neg;

    assign quad = i_quad_idx[QTB+1:QTB];
    assign idx  = i_quad_idx[QTB-1:0];

    // Mirror the index in odd quadrants; the peak sits just past the table
    assign addr = quad[0] ? QTB'(~idx + 1'b1) : idx;
    assign pole = quad[0] && (idx == '0);

    // Read the table and hold until the next request
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_mag <= pole ? essg_pkg::AMP : SINE_ROM[addr];
            r_neg <= quad[1];
        end
    end

    assign o_rd.neg = r_neg;
    assign o_rd.mag = r_mag;

endmodule
